// ===== rtl/bust_pkg.sv =====
package bust_pkg;

   // table geometry
   localparam int DEPTH = 16;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = 5;
   localparam int VAL_W = 32;
   localparam int FUNC_W = 2;

   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;
   localparam logic signed [VAL_W-1:0] NOT_FOUND = -32'sd32767;

   // operation codes
   localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

   typedef struct packed {
      logic [FUNC_W-1:0]       func;
      logic signed [VAL_W-1:0] operand_value;
   } req_type;

   typedef struct packed {
      logic                    success;
      logic signed [VAL_W-1:0] returned_value;
      logic [CNT_W-1:0]        entry_count;
   } rsp_type;

   // finished result handed from the sequencer to the output register
   typedef struct packed {
      logic    valid;
      rsp_type data;
   } done_type;

   // one write and one read port on the entry store
   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic [VAL_W-1:0] wr_data;
      logic [IDX_W-1:0] rd_addr;
   } ram_req_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_SCAN,
      ST_SHIFT,
      ST_FINISH
   } state_type;

endpackage

// ===== rtl/bust_ram.sv =====
module bust_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bust_ctrl.sv =====
module bust_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  bust_pkg::req_type                 req,
   input  logic [bust_pkg::CNT_W-1:0]        cap_limit,
   input  logic                              take,
   input  logic [bust_pkg::VAL_W-1:0]        rd_data,
   output bust_pkg::ram_req_type             ram_req,
   output bust_pkg::done_type                done,
   output logic                              idle
);

   bust_pkg::state_type state_ff, state_in;

   logic [bust_pkg::FUNC_W-1:0]       func_ff, func_in;
   logic [bust_pkg::VAL_W-1:0]        key_ff, key_in;
   logic [bust_pkg::IDX_W-1:0]        idx_ff, idx_in;
   logic [bust_pkg::CNT_W-1:0]        count_ff, count_in;
   logic                              ok_ff, ok_in;
   logic signed [bust_pkg::VAL_W-1:0] ret_ff, ret_in;

   logic [bust_pkg::CNT_W-1:0] eff_cap;
   logic [bust_pkg::CNT_W-1:0] idx_next;
   logic                       match;
   logic                       last_scan;
   logic                       last_shift;
   logic                       can_insert;
   logic                       is_search;

   // shared compare and index arithmetic
   assign eff_cap    = (cap_limit > bust_pkg::DEPTH_CNT) ? bust_pkg::DEPTH_CNT : cap_limit;
   assign idx_next   = bust_pkg::CNT_W'(idx_ff) + 1'b1;
   assign match      = (rd_data == key_ff);
   assign last_scan  = (idx_next >= count_ff);
   assign last_shift = (idx_next > count_ff);
   assign can_insert = (count_ff < eff_cap);
   assign is_search  = (func_ff == bust_pkg::FUNC_REMOVE) || (func_ff == bust_pkg::FUNC_QUERY);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bust_pkg::ST_IDLE: begin
            if (start) state_in = bust_pkg::ST_START;
         end
         bust_pkg::ST_START: begin
            if (is_search && (count_ff != '0)) state_in = bust_pkg::ST_SCAN;
            else state_in = bust_pkg::ST_FINISH;
         end
         bust_pkg::ST_SCAN: begin
            priority if (match && (func_ff == bust_pkg::FUNC_REMOVE) && !last_scan)
               state_in = bust_pkg::ST_SHIFT;
            else if (match || last_scan)
               state_in = bust_pkg::ST_FINISH;
            else
               state_in = bust_pkg::ST_SCAN;
         end
         bust_pkg::ST_SHIFT: begin
            if (last_shift) state_in = bust_pkg::ST_FINISH;
         end
         bust_pkg::ST_FINISH: begin
            if (take) state_in = bust_pkg::ST_IDLE;
         end
         default: state_in = bust_pkg::ST_IDLE;
      endcase
   end

   // datapath and store access
   always_comb begin
      func_in  = func_ff;
      key_in   = key_ff;
      idx_in   = idx_ff;
      count_in = count_ff;
      ok_in    = ok_ff;
      ret_in   = ret_ff;
      ram_req  = '0;
      ram_req.rd_addr = idx_next[bust_pkg::IDX_W-1:0];
      unique case (state_ff)
         bust_pkg::ST_IDLE: begin
            if (start) begin
               func_in = req.func;
               key_in  = req.operand_value;
            end
         end
         bust_pkg::ST_START: begin
            ok_in  = 1'b0;
            ret_in = bust_pkg::NOT_FOUND;
            idx_in = '0;
            ram_req.rd_addr = '0;
            if ((func_ff == bust_pkg::FUNC_INSERT) && can_insert) begin
               ram_req.wr_en   = 1'b1;
               ram_req.wr_addr = count_ff[bust_pkg::IDX_W-1:0];
               ram_req.wr_data = key_ff;
               count_in = count_ff + 1'b1;
               ok_in    = 1'b1;
            end
         end
         bust_pkg::ST_SCAN: begin
            idx_in = idx_next[bust_pkg::IDX_W-1:0];
            if (match) begin
               ok_in = 1'b1;
               if (func_ff == bust_pkg::FUNC_REMOVE) begin
                  ret_in   = rd_data;
                  count_in = count_ff - 1'b1;
               end
            end
         end
         bust_pkg::ST_SHIFT: begin
            // move the entry just read down by one slot
            idx_in          = idx_next[bust_pkg::IDX_W-1:0];
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = idx_ff - 1'b1;
            ram_req.wr_data = rd_data;
         end
         bust_pkg::ST_FINISH: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bust_pkg::ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      func_ff <= func_in;
      key_ff  <= key_in;
      idx_ff  <= idx_in;
      ok_ff   <= ok_in;
      ret_ff  <= ret_in;
   end

   assign idle                     = (state_ff == bust_pkg::ST_IDLE);
   assign done.valid               = (state_ff == bust_pkg::ST_FINISH);
   assign done.data.success        = ok_ff;
   assign done.data.returned_value = ret_ff;
   assign done.data.entry_count    = count_ff;

endmodule

// ===== rtl/bounded_unordered_set_table_top.sv =====
// Channel   Direction  Ports                                 Transaction
// req       in         req_valid, req_stall, req_data        func and operand_value
// rsp       out        rsp_valid, rsp_stall, rsp_data        success, returned_value, count
// csr       in         csr_valid, csr_ready, csr_wdata       capacity_limit write
//
// Insert writes its entry in the start state and then finishes. Query and remove
// compare at most once per occupied slot through the single read port of the
// entry store; a remove then moves each later entry down one per cycle.
// Synchronous reset empties the table and sets capacity to 16; csr is always ready.
// The result sits in an output register; req stays stalled while an item is in work.
module bounded_unordered_set_table_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  bust_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output bust_pkg::rsp_type              rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bust_pkg::CNT_W-1:0]     csr_wdata
);

   logic [bust_pkg::CNT_W-1:0] cap_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   bust_pkg::rsp_type          rsp_data_ff;
   bust_pkg::ram_req_type      ram_req;
   bust_pkg::done_type         done;
   logic [bust_pkg::VAL_W-1:0] rd_data;
   logic                       idle;
   logic                       start;
   logic                       take;

   assign csr_ready = 1'b1;
   assign req_stall = !idle;
   assign start     = req_valid && idle;
   assign take      = done.valid && (!rsp_valid_ff || !rsp_stall);

   // capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= bust_pkg::CAP_RESET;
      end else if (csr_valid && csr_ready) begin
         cap_ff <= csr_wdata;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (take) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (take) begin
         rsp_data_ff <= done.data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   bust_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req       (req_data),
      .cap_limit (cap_ff),
      .take      (take),
      .rd_data   (rd_data),
      .ram_req   (ram_req),
      .done      (done),
      .idle      (idle)
   );

   bust_ram #(
      .WIDTH (bust_pkg::VAL_W),
      .DEPTH (bust_pkg::DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .wr_addr (ram_req.wr_addr),
      .wr_data (ram_req.wr_data),
      .rd_addr (ram_req.rd_addr),
      .rd_data (rd_data)
   );

   // an accepted request keeps the input stalled on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input not stalled after accept");

   // count never exceeds the table depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.entry_count <= bust_pkg::DEPTH_CNT))
      else $error("entry count above depth");

   // a failed operation always returns the sentinel
   a_fail_sentinel: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.success) |-> (rsp_data.returned_value == bust_pkg::NOT_FOUND))
      else $error("failed operation returned a key");

   // a result is only loaded when the output slot is free or draining
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result overwritten");

endmodule
